/* rtl/core/salc_pkg.sv */
// Shared constants, codes and types for the set-associative LRU cache model.
package salc_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;

    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_SETS = 1 << SET_W;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
    localparam int RANK_W   = WAY_W;

    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_STORE  = 2'd1,
        KIND_MODIFY = 2'd2,
        KIND_OTHER  = 2'd3
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    typedef struct packed {
        logic [MAX_WAYS-1:0]             vld;
        logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    } t_row;

    typedef struct packed {
        logic              found;
        logic [WAY_W-1:0]  hit_way;
        logic              have_inv;
        logic [WAY_W-1:0]  inv_way;
        logic [WAY_W-1:0]  best_way;
        logic [RANK_W-1:0] best_rank;
    } t_scan;

endpackage

/* rtl/core/salc_row_store.sv */
// Set row memory with per-set fill flags cleared at reset.
module salc_row_store (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [salc_pkg::SET_W-1:0] i_rd_set,
    output salc_pkg::t_row           o_rd_row,
    input  logic                     i_wr_en,
    input  logic [salc_pkg::SET_W-1:0] i_wr_set,
    input  salc_pkg::t_row           i_wr_row
);
    import salc_pkg::*;

    t_row              r_mem [NUM_SETS];
    t_row              r_rd_data;
    logic [NUM_SETS-1:0] r_row_ok;
    logic              r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_set] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_ok[i_wr_set] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_row_ok[i_rd_set];
            end
        end
    end

    // An unfilled set reads as empty with zero ranks.
    assign o_rd_row = r_rd_ok ? r_rd_data : '0;

endmodule

/* rtl/core/salc_way_scan.sv */
// Shared per-way compare unit: tag match, first empty way and oldest way.
module salc_way_scan (
    input  logic                       i_clk,
    input  logic                       i_start,
    input  logic                       i_step,
    input  logic [salc_pkg::WAY_W-1:0] i_way,
    input  salc_pkg::t_row             i_row,
    input  logic [salc_pkg::TAG_W-1:0] i_tag,
    output salc_pkg::t_scan            o_scan
);
    import salc_pkg::*;

    t_scan             r_scan;
    logic              w_vld;
    logic [TAG_W-1:0]  w_tag;
    logic [RANK_W-1:0] w_rank;

    assign w_vld  = i_row.vld[i_way];
    assign w_tag  = i_row.tag[i_way];
    assign w_rank = i_row.rank[i_way];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_scan <= '0;
        end else if (i_step) begin
            if (!r_scan.found && w_vld && (w_tag == i_tag)) begin
                r_scan.found   <= 1'b1;
                r_scan.hit_way <= i_way;
            end
            if (!r_scan.have_inv && !w_vld) begin
                r_scan.have_inv <= 1'b1;
                r_scan.inv_way  <= i_way;
            end
            if ((i_way == '0) || (w_rank > r_scan.best_rank)) begin
                r_scan.best_way  <= i_way;
                r_scan.best_rank <= w_rank;
            end
        end
    end

    assign o_scan = r_scan;

endmodule

/* rtl/core/set_assoc_lru_cache_sim.sv */
// Top level of the set-associative LRU cache model: sequencer, counters, ports.
// Each access reads its set's row, then walks the ways in use through one
// shared tag compare unit, one way per cycle, and writes the updated row back.
// A load, store or modify holds the block through the load state, one scan
// state per way in use (effective ways 1 to 8) and the update state; an access
// of the other kind goes from idle straight to the update state. Either result
// is registered as the update state hands the sequencer back to idle.
// The result sits in an output register; the next access is
// accepted as soon as the sequencer is back in idle, and its write-back waits
// only if the previous result has still not been taken. Sets start empty
// straight out of reset through per-set fill flags, so there is no clearing
// pass. Configuration registers may be written at any time the block is idle.
module set_assoc_lru_cache_sim (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [salc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_kind,
    input  logic [salc_pkg::ADDR_W-1:0]     i_address,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_was_hit,
    output logic                            o_was_miss,
    output logic                            o_was_eviction,
    output logic                            o_extra_hit,
    output logic [salc_pkg::CNT_W-1:0]      o_total_hits,
    output logic [salc_pkg::CNT_W-1:0]      o_total_misses,
    output logic [salc_pkg::CNT_W-1:0]      o_total_evictions
);
    import salc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_UPD
    } t_state;

    t_state           r_state;
    t_kind            r_kind;
    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;
    logic [WAY_W-1:0] r_way;

    logic [2:0] r_cfg_set_bits;
    logic [3:0] r_cfg_ways;
    logic [4:0] r_cfg_block_bits;

    logic [CNT_W-1:0] r_hits;
    logic [CNT_W-1:0] r_misses;
    logic [CNT_W-1:0] r_evictions;

    logic r_out_valid;
    logic r_was_hit;
    logic r_was_miss;
    logic r_was_eviction;
    logic r_extra_hit;

    logic              w_in_fire;
    logic              w_upd_go;
    logic              w_lookup;
    logic [2:0]        w_eff_s;
    logic [WCNT_W-1:0] w_ways;
    logic [ADDR_W-1:0] w_shifted;
    logic [SET_W-1:0]  w_set_mask;
    logic [SET_W-1:0]  n_set;
    logic [5:0]        w_tag_shift;
    logic [TAG_W-1:0]  n_tag;
    logic              w_last_way;

    t_row              w_rd_row;
    t_row              n_row;
    t_scan             w_scan;
    logic [WAY_W-1:0]  w_target;
    logic              w_age_all;
    logic              w_evict;
    logic [RANK_W-1:0] w_limit;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_upd_go    = (r_state == S_UPD) && (!r_out_valid || i_out_ready);
    assign w_lookup    = (r_kind != KIND_OTHER);

    // Effective configuration
    always_comb begin
        if (r_cfg_set_bits > MAX_SET_BITS) begin
            w_eff_s = 3'(MAX_SET_BITS);
        end else begin
            w_eff_s = r_cfg_set_bits;
        end
        if (r_cfg_ways == 4'd0) begin
            w_ways = WCNT_W'(1);
        end else if (r_cfg_ways > MAX_WAYS) begin
            w_ways = WCNT_W'(MAX_WAYS);
        end else begin
            w_ways = WCNT_W'(r_cfg_ways);
        end
    end

    // Address split
    assign w_shifted   = i_address >> r_cfg_block_bits;
    assign w_set_mask  = ~({SET_W{1'b1}} << w_eff_s);
    assign n_set       = w_shifted[SET_W-1:0] & w_set_mask;
    assign w_tag_shift = 6'(r_cfg_block_bits) + 6'(w_eff_s);
    assign n_tag       = w_tag_shift[5] ? '0 : (i_address >> w_tag_shift[4:0]);

    assign w_last_way = (WCNT_W'(r_way) == (w_ways - WCNT_W'(1)));

    salc_row_store u_row_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (w_in_fire),
        .i_rd_set (n_set),
        .o_rd_row (w_rd_row),
        .i_wr_en  (w_upd_go && w_lookup),
        .i_wr_set (r_set),
        .i_wr_row (n_row)
    );

    salc_way_scan u_way_scan (
        .i_clk   (i_clk),
        .i_start (r_state == S_LOAD),
        .i_step  (r_state == S_SCAN),
        .i_way   (r_way),
        .i_row   (w_rd_row),
        .i_tag   (r_tag),
        .o_scan  (w_scan)
    );

    // Victim choice and rank update
    always_comb begin
        w_age_all = !w_scan.found && w_scan.have_inv;
        w_evict   = !w_scan.found && !w_scan.have_inv;
        if (w_scan.found) begin
            w_target = w_scan.hit_way;
        end else if (w_scan.have_inv) begin
            w_target = w_scan.inv_way;
        end else begin
            w_target = w_scan.best_way;
        end
        w_limit = w_rd_row.rank[w_target];
        n_row   = w_rd_row;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if ((WCNT_W'(i) < w_ways) && (WAY_W'(i) != w_target) && w_rd_row.vld[i]
                && (w_age_all || (w_rd_row.rank[i] < w_limit))
                && (w_rd_row.rank[i] < RANK_MAX)) begin
                n_row.rank[i] = w_rd_row.rank[i] + RANK_W'(1);
            end
        end
        n_row.rank[w_target] = '0;
        if (!w_scan.found) begin
            n_row.vld[w_target] = 1'b1;
            n_row.tag[w_target] = r_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_set_bits   <= 3'd0;
            r_cfg_ways       <= 4'd1;
            r_cfg_block_bits <= 5'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SET_BITS:   r_cfg_set_bits   <= i_cfg_data[2:0];
                CFG_WAYS:       r_cfg_ways       <= i_cfg_data[3:0];
                CFG_BLOCK_BITS: r_cfg_block_bits <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_kind         <= KIND_LOAD;
            r_set          <= '0;
            r_tag          <= '0;
            r_way          <= '0;
            r_hits         <= '0;
            r_misses       <= '0;
            r_evictions    <= '0;
            r_out_valid    <= 1'b0;
            r_was_hit      <= 1'b0;
            r_was_miss     <= 1'b0;
            r_was_eviction <= 1'b0;
            r_extra_hit    <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !w_upd_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_kind <= t_kind'(i_kind);
                        r_set  <= n_set;
                        r_tag  <= n_tag;
                        r_way  <= '0;
                        r_state <= (t_kind'(i_kind) == KIND_OTHER) ? S_UPD : S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_last_way) begin
                        r_state <= S_UPD;
                    end else begin
                        r_way <= r_way + WAY_W'(1);
                    end
                end
                S_UPD: begin
                    if (w_upd_go) begin
                        r_out_valid    <= 1'b1;
                        r_was_hit      <= w_lookup && w_scan.found;
                        r_was_miss     <= w_lookup && !w_scan.found;
                        r_was_eviction <= w_lookup && w_evict;
                        r_extra_hit    <= (r_kind == KIND_MODIFY);
                        if (w_lookup) begin
                            r_hits <= r_hits + CNT_W'(w_scan.found)
                                    + CNT_W'(r_kind == KIND_MODIFY);
                            r_misses    <= r_misses + CNT_W'(!w_scan.found);
                            r_evictions <= r_evictions + CNT_W'(w_evict);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_was_hit         = r_was_hit;
    assign o_was_miss        = r_was_miss;
    assign o_was_eviction    = r_was_eviction;
    assign o_extra_hit       = r_extra_hit;
    assign o_total_hits      = r_hits;
    assign o_total_misses    = r_misses;
    assign o_total_evictions = r_evictions;

endmodule

/* bench/lru_cache_checker.sv */
// Checker for the LRU cache model: watches all channels, predicts each result and compares.
module lru_cache_checker
    import salc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [1:0]            i_kind,
    input  logic [ADDR_W-1:0]     i_address,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_was_hit,
    input  logic                  i_was_miss,
    input  logic                  i_was_eviction,
    input  logic                  i_extra_hit,
    input  logic [CNT_W-1:0]      i_total_hits,
    input  logic [CNT_W-1:0]      i_total_misses,
    input  logic [CNT_W-1:0]      i_total_evictions,
    output int                    o_mismatches,
    output int                    o_pending
);

    localparam int LINES = NUM_SETS * MAX_WAYS;

    typedef struct packed {
        logic             hit;
        logic             miss;
        logic             evict;
        logic             extra;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] evictions;
    } t_outcome;

    logic              line_vld  [LINES];
    logic [TAG_W-1:0]  line_tag  [LINES];
    logic [RANK_W-1:0] line_rank [LINES];

    logic [2:0]       cfg_set_bits;
    logic [3:0]       cfg_ways;
    logic [4:0]       cfg_block_bits;
    logic [CNT_W-1:0] n_hits;
    logic [CNT_W-1:0] n_misses;
    logic [CNT_W-1:0] n_evictions;

    t_outcome expected_outcomes[$];
    int       bad_results = 0;

    function automatic logic [ADDR_W-1:0] shift_down(input logic [ADDR_W-1:0] x, input int n);
        return (n >= ADDR_W) ? '0 : (x >> n);
    endfunction

    // Move one way to most recent; valid ways ranked below limit age by one, saturating at RANK_MAX.
    task automatic age_set(input int base, input int way, input int limit, input int ways);
        for (int i = 0; i < ways; i++) begin
            if (i != way && line_vld[base+i] && int'(line_rank[base+i]) < limit
                    && line_rank[base+i] != RANK_MAX) begin
                line_rank[base+i] = line_rank[base+i] + 1'b1;
            end
        end
        line_rank[base+way] = '0;
    endtask

    task automatic lookup_and_fill(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                                   output t_outcome r);
        int               s;
        int               b;
        int               ways;
        int               base;
        int               way;
        int               victim;
        logic             found;
        logic [TAG_W-1:0] tag;
        logic [ADDR_W-1:0] set_mask;
        r = '0;
        if (kind != KIND_OTHER) begin
            s        = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_set_bits);
            b        = int'(cfg_block_bits);
            ways     = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways));
            set_mask = (s == 0) ? '0 : ADDR_W'((64'd1 << s) - 1);
            base     = int'(shift_down(addr, b) & set_mask & ADDR_W'(NUM_SETS - 1)) * MAX_WAYS;
            tag      = shift_down(addr, b + s);
            found    = 1'b0;
            way      = 0;
            for (int i = 0; i < ways; i++) begin
                if (!found && line_vld[base+i] && line_tag[base+i] == tag) begin
                    found = 1'b1;
                    way   = i;
                end
            end
            if (found) begin
                r.hit  = 1'b1;
                n_hits = n_hits + 1'b1;
                age_set(base, way, int'(line_rank[base+way]), ways);
            end else begin
                r.miss   = 1'b1;
                n_misses = n_misses + 1'b1;
                victim   = ways;
                for (int i = ways - 1; i >= 0; i--) begin
                    if (!line_vld[base+i]) victim = i;
                end
                if (victim == ways) begin
                    r.evict     = 1'b1;
                    n_evictions = n_evictions + 1'b1;
                    victim      = 0;
                    for (int i = 1; i < ways; i++) begin
                        if (line_rank[base+i] > line_rank[base+victim]) victim = i;
                    end
                    age_set(base, victim, int'(line_rank[base+victim]), ways);
                end else begin
                    age_set(base, victim, 256, ways);
                end
                line_vld[base+victim] = 1'b1;
                line_tag[base+victim] = tag;
            end
            if (kind == KIND_MODIFY) begin
                r.extra = 1'b1;
                n_hits  = n_hits + 1'b1;
            end
        end
        r.hits      = n_hits;
        r.misses    = n_misses;
        r.evictions = n_evictions;
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            for (int i = 0; i < LINES; i++) begin
                line_vld[i]  = 1'b0;
                line_tag[i]  = '0;
                line_rank[i] = '0;
            end
            cfg_set_bits   = 3'd0;
            cfg_ways       = 4'd1;
            cfg_block_bits = 5'd0;
            n_hits         = '0;
            n_misses       = '0;
            n_evictions    = '0;
            expected_outcomes.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = {i_was_hit, i_was_miss, i_was_eviction, i_extra_hit,
                       i_total_hits, i_total_misses, i_total_evictions};
                if (expected_outcomes.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("unexpected result beat: hit %0b miss %0b evict %0b extra %0b",
                                 got.hit, got.miss, got.evict, got.extra);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (got.hit !== want.hit || got.miss !== want.miss
                            || got.evict !== want.evict || got.extra !== want.extra
                            || got.hits !== want.hits || got.misses !== want.misses
                            || got.evictions !== want.evictions) begin
                        bad_results++;
                        if (bad_results <= 10) begin
                            $display("result mismatch: expected hit %0b miss %0b evict %0b extra %0b",
                                     want.hit, want.miss, want.evict, want.extra,
                                     " hits %0d misses %0d evictions %0d",
                                     want.hits, want.misses, want.evictions);
                            $display("                 actual   hit %0b miss %0b evict %0b extra %0b",
                                     got.hit, got.miss, got.evict, got.extra,
                                     " hits %0d misses %0d evictions %0d",
                                     got.hits, got.misses, got.evictions);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SET_BITS: begin
                        cfg_set_bits = i_cfg_data[2:0];
                    end
                    CFG_WAYS: begin
                        cfg_ways = i_cfg_data[3:0];
                    end
                    CFG_BLOCK_BITS: begin
                        cfg_block_bits = i_cfg_data[4:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                lookup_and_fill(i_kind, i_address, want);
                expected_outcomes.push_back(want);
            end
        end
        o_pending    <= expected_outcomes.size();
        o_mismatches <= bad_results;
    end

endmodule

/* bench/tb_top.sv */
// Testbench top for the LRU cache model: clock, reset, stimulus and verdict.
module tb_top;
    import salc_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            kind = '0;
    logic [ADDR_W-1:0]     address = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  was_hit;
    logic                  was_miss;
    logic                  was_eviction;
    logic                  extra_hit;
    logic [CNT_W-1:0]      total_hits;
    logic [CNT_W-1:0]      total_misses;
    logic [CNT_W-1:0]      total_evictions;
    int                    mismatches;
    int                    pending;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_len = 0;
    int   hold_left = 0;
    logic hold_kick = 1'b0;
    logic hold_seen = 1'b0;
    int   cur_s = 0;
    int   cur_b = 0;
    int   cur_w = 1;

    int phase_s[8]    = '{2, 6, 0, 3, 1, 7, 4, 0};
    int phase_w[8]    = '{4, 8, 1, 8, 3, 15, 0, 2};
    int phase_b[8]    = '{4, 26, 0, 6, 2, 5, 31, 3};
    int phase_send[8] = '{0, 47, 0, 23, 0, 47, 0, 23};
    int phase_recv[8] = '{0, 0, 47, 23, 0, 0, 47, 23};

    set_assoc_lru_cache_sim u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_kind            (kind),
        .i_address         (address),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_was_hit         (was_hit),
        .o_was_miss        (was_miss),
        .o_was_eviction    (was_eviction),
        .o_extra_hit       (extra_hit),
        .o_total_hits      (total_hits),
        .o_total_misses    (total_misses),
        .o_total_evictions (total_evictions)
    );

    lru_cache_checker u_chk (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_kind            (kind),
        .i_address         (address),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_was_hit         (was_hit),
        .i_was_miss        (was_miss),
        .i_was_eviction    (was_eviction),
        .i_extra_hit       (extra_hit),
        .i_total_hits      (total_hits),
        .i_total_misses    (total_misses),
        .i_total_evictions (total_evictions),
        .o_mismatches      (mismatches),
        .o_pending         (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // Hold off the receiver for a counted stretch when asked, else stall at random.
    always @(posedge clk) begin
        if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= hold_len;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_access(input t_kind k, input logic [ADDR_W-1:0] a);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        address  <= a;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_phase(input int s, input int w, input int b,
                             input int send_pct, input int recv_pct);
        drain();
        write_reg(CFG_SET_BITS, s);
        write_reg(CFG_WAYS, w);
        write_reg(CFG_BLOCK_BITS, b);
        cfg_valid      <= 1'b0;
        cur_s          = (s > MAX_SET_BITS) ? MAX_SET_BITS : s;
        cur_w          = (w == 0) ? 1 : ((w > MAX_WAYS) ? MAX_WAYS : w);
        cur_b          = b;
        send_idle_pct  = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Mostly a small pool of tags over a few sets, so that hits and evictions occur.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [63:0] a;
        logic [63:0] set_mask;
        if ($urandom_range(99) < 15) return $urandom();
        set_mask = (64'd1 << cur_s) - 1;
        a = 64'($urandom_range(0, cur_w + 2)) << (cur_b + cur_s);
        a = a | ((64'($urandom_range(0, 3)) & set_mask) << cur_b);
        a = a | (64'($urandom()) & ((64'd1 << cur_b) - 1));
        return a[ADDR_W-1:0];
    endfunction

    initial begin
        int    accesses;
        t_kind k;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_phase(2, 2, 4, 0, 0);
        send_access(KIND_LOAD,   32'h0000_0000);
        send_access(KIND_LOAD,   32'h0000_0000);
        send_access(KIND_STORE,  32'h0000_000F);
        send_access(KIND_MODIFY, 32'h0000_0040);
        send_access(KIND_LOAD,   32'h0000_0080);
        send_access(KIND_LOAD,   32'h0000_0000);
        send_access(KIND_MODIFY, 32'h0000_0080);
        send_access(KIND_OTHER,  32'hFFFF_FFFF);
        send_access(KIND_LOAD,   32'hFFFF_FFFF);
        send_access(KIND_STORE,  32'hFFFF_FFFF);
        send_access(KIND_LOAD,   32'hAAAA_AAAA);
        send_access(KIND_STORE,  32'h5555_5555);

        set_phase(7, 15, 31, 0, 0);
        send_access(KIND_LOAD,   32'h8000_0000);
        send_access(KIND_LOAD,   32'h0000_0000);
        send_access(KIND_MODIFY, 32'h7FFF_FFFF);
        send_access(KIND_STORE,  32'h8000_0001);

        set_phase(6, 8, 26, 0, 0);
        send_access(KIND_LOAD,   32'hFC00_0000);
        send_access(KIND_LOAD,   32'h0000_0000);

        set_phase(0, 0, 0, 0, 0);
        send_access(KIND_LOAD,   32'h1234_5678);
        send_access(KIND_LOAD,   32'h1234_5678);
        send_access(KIND_STORE,  32'h8765_4321);
        send_access(KIND_OTHER,  32'h0000_0000);

        for (int p = 0; p < 8; p++) begin
            if (p == 7) begin
                phase_s[p] = $urandom_range(0, 7);
                phase_w[p] = $urandom_range(0, 15);
                phase_b[p] = $urandom_range(0, 31);
            end
            set_phase(phase_s[p], phase_w[p], phase_b[p], phase_send[p], phase_recv[p]);
            if (p == 0) begin
                hold_len  <= 400;
                hold_kick <= ~hold_kick;
            end
            accesses = 0;
            while (accesses < 150) begin
                k = ($urandom_range(9) == 0) ? KIND_OTHER : t_kind'($urandom_range(0, 2));
                send_access(k, pick_address());
                if (k != KIND_OTHER) accesses++;
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
